>>> src/plnt_pkg.sv
`timescale 1ns / 1ps

package plnt_pkg;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned COUNT_W = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_FIND   = 2'd2
    } req_kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD1,
        ST_ADD2,
        ST_ADD3,
        ST_DEL1,
        ST_DEL2,
        ST_DEL3,
        ST_FIND,
        ST_DONE
    } state_t;

    // Keep the low nbytes bytes up to the first zero byte.
    function automatic logic [KEY_W-1:0] canon_name(input logic [KEY_W-1:0] key,
                                                    input int unsigned nbytes);
        logic [KEY_W-1:0] res;
        logic             stop;
        res  = '0;
        stop = 1'b0;
        for (int unsigned i = 0; i < KEY_W / 8; i++)
        begin
            if (i >= nbytes || key[8*i +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                res[8*i +: 8] = key[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

>>> src/plnt_if.sv
`timescale 1ns / 1ps

interface plnt_req_if;
    logic                          valid;
    logic                          ready;
    logic [plnt_pkg::REQ_W-1:0]    req_type;
    logic [plnt_pkg::KEY_W-1:0]    name_key;
    logic [plnt_pkg::SLOT_W-1:0]   slot_handle;
    logic                          handle_valid;

    modport source (output valid, output req_type, output name_key,
                    output slot_handle, output handle_valid, input ready);
    modport sink   (input valid, input req_type, input name_key,
                    input slot_handle, input handle_valid, output ready);
endinterface

interface plnt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [plnt_pkg::SLOT_W-1:0]   result_slot;
    logic [plnt_pkg::COUNT_W-1:0]  entry_count;
    logic [plnt_pkg::SLOT_W-1:0]   head_slot;
    logic                          head_valid;

    modport source (output valid, output ok, output result_slot, output entry_count,
                    output head_slot, output head_valid, input ready);
    modport sink   (input valid, input ok, input result_slot, input entry_count,
                    input head_slot, input head_valid, output ready);
endinterface

>>> src/pooled_list_name_table_core.sv
`timescale 1ns / 1ps

// Pooled name table: free and used chains in block RAM; reset empties the used chain and
// runs a clearing pass that sets up the chains, takes no beat and drops any pending result.
// From request beat to result: add goes ADD1, ADD2, ADD3, DONE; delete DEL1, DEL2, DEL3,
// DONE; delete of an unused slot DEL1, DONE; find one RAM read per entry walked, then DONE;
// full-pool add, empty-table find, null handle and unknown go straight to DONE. One request
// at a time; the next beat can be taken at the edge the result beat goes.
module pooled_list_name_table_core #(
    parameter int unsigned POOL_ENTRIES = 32,
    parameter int unsigned NAME_BYTES   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    plnt_req_if.sink     req,
    plnt_rsp_if.source   rsp
);

    import plnt_pkg::*;

    localparam int unsigned IDX_W  = $clog2(POOL_ENTRIES);
    localparam int unsigned LINK_W = $clog2(POOL_ENTRIES + 1);
    localparam int unsigned CNT_W  = $clog2(POOL_ENTRIES + 1);
    localparam int unsigned EXT_W  = (LINK_W > SLOT_W) ? LINK_W : SLOT_W;
    localparam int unsigned CEXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_ENTRIES);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

    state_t             state_reg, state_next;
    logic [LINK_W-1:0]  free_head_reg, free_head_next;
    logic [LINK_W-1:0]  used_head_reg, used_head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [LINK_W-1:0]  aux_reg, aux_next;
    logic               ok_reg, ok_next;
    logic [IDX_W-1:0]   result_reg, result_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [SLOT_W-1:0]  out_head_reg, out_head_next;
    logic               out_head_valid_reg, out_head_valid_next;

    logic               accept;
    logic [EXT_W-1:0]   handle_ext;
    logic               handle_bad;
    logic               key_match;
    logic [EXT_W-1:0]   result_ext;
    logic [EXT_W-1:0]   head_ext;
    logic [CEXT_W-1:0]  count_ext;

    logic [IDX_W-1:0]   rd_addr;
    logic               name_we, next_we, prev_we, use_we;
    logic [IDX_W-1:0]   name_waddr, next_waddr, prev_waddr, use_waddr;
    logic [KEY_W-1:0]   name_wdata, name_rd;
    logic [LINK_W-1:0]  next_wdata, prev_wdata, next_rd, prev_rd;
    logic               use_wdata, use_rd;

    plnt_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_name_ram (
        .clk     (clk),
        .wr_en   (name_we),
        .wr_addr (name_waddr),
        .wr_data (name_wdata),
        .rd_addr (rd_addr),
        .rd_data (name_rd)
    );

    plnt_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    plnt_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_waddr),
        .wr_data (prev_wdata),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    plnt_ram #(.WIDTH(1), .DEPTH(POOL_ENTRIES)) u_use_ram (
        .clk     (clk),
        .wr_en   (use_we),
        .wr_addr (use_waddr),
        .wr_data (use_wdata),
        .rd_addr (rd_addr),
        .rd_data (use_rd)
    );

    assign req.ready  = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;
    assign handle_ext = EXT_W'(req.slot_handle);
    assign handle_bad = handle_ext >= EXT_W'(POOL_ENTRIES);
    assign key_match  = name_rd == key_reg;
    assign result_ext = EXT_W'(result_reg);
    assign head_ext   = EXT_W'(used_head_reg);
    assign count_ext  = CEXT_W'(count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (slot_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            state_next = (free_head_reg == NIL_LINK) ? ST_DONE : ST_ADD1;
                        end
                        REQ_DELETE:
                        begin
                            state_next = (!req.handle_valid || handle_bad) ? ST_DONE : ST_DEL1;
                        end
                        REQ_FIND:
                        begin
                            state_next = (used_head_reg == NIL_LINK) ? ST_DONE : ST_FIND;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADD1: state_next = ST_ADD2;
            ST_ADD2: state_next = ST_ADD3;
            ST_ADD3: state_next = ST_DONE;
            ST_DEL1: state_next = use_rd ? ST_DEL2 : ST_DONE;
            ST_DEL2: state_next = ST_DEL3;
            ST_DEL3: state_next = ST_DONE;
            ST_FIND:
            begin
                if (key_match || next_rd == NIL_LINK)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_INIT;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        free_head_next      = free_head_reg;
        used_head_next      = used_head_reg;
        count_next          = count_reg;
        key_next            = key_reg;
        slot_next           = slot_reg;
        aux_next            = aux_reg;
        ok_next             = ok_reg;
        result_next         = result_reg;
        out_valid_next      = out_valid_reg && !rsp.ready;
        out_ok_next         = out_ok_reg;
        out_slot_next       = out_slot_reg;
        out_count_next      = out_count_reg;
        out_head_next       = out_head_reg;
        out_head_valid_next = out_head_valid_reg;

        rd_addr    = slot_reg;
        name_we    = 1'b0;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        use_we     = 1'b0;
        name_waddr = slot_reg;
        next_waddr = slot_reg;
        prev_waddr = slot_reg;
        use_waddr  = slot_reg;
        name_wdata = key_reg;
        next_wdata = NIL_LINK;
        prev_wdata = NIL_LINK;
        use_wdata  = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                use_we     = 1'b1;
                next_wdata = LINK_W'(slot_reg) + LINK_W'(1);
                prev_wdata = (slot_reg == '0) ? NIL_LINK : LINK_W'(slot_reg) - LINK_W'(1);
                slot_next  = slot_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                case (req.req_type)
                    REQ_ADD:    rd_addr = free_head_reg[IDX_W-1:0];
                    REQ_DELETE: rd_addr = handle_ext[IDX_W-1:0];
                    REQ_FIND:   rd_addr = used_head_reg[IDX_W-1:0];
                    default:    rd_addr = slot_reg;
                endcase
                if (accept)
                begin
                    key_next    = canon_name(req.name_key, NAME_BYTES);
                    slot_next   = rd_addr;
                    ok_next     = 1'b0;
                    result_next = '0;
                    if (req.req_type == REQ_DELETE && !req.handle_valid)
                    begin
                        ok_next = 1'b1;
                    end
                end
            end
            ST_ADD1:
            begin
                aux_next   = next_rd;
                next_we    = 1'b1;
                next_wdata = used_head_reg;
                prev_we    = 1'b1;
                name_we    = 1'b1;
                use_we     = 1'b1;
                use_wdata  = 1'b1;
            end
            ST_ADD2:
            begin
                prev_we    = used_head_reg != NIL_LINK;
                prev_waddr = used_head_reg[IDX_W-1:0];
                prev_wdata = LINK_W'(slot_reg);
            end
            ST_ADD3:
            begin
                prev_we        = aux_reg != NIL_LINK;
                prev_waddr     = aux_reg[IDX_W-1:0];
                used_head_next = LINK_W'(slot_reg);
                free_head_next = aux_reg;
                count_next     = count_reg + CNT_W'(1);
                ok_next        = 1'b1;
                result_next    = slot_reg;
            end
            ST_DEL1:
            begin
                if (use_rd)
                begin
                    if (prev_rd != NIL_LINK)
                    begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd[IDX_W-1:0];
                        next_wdata = next_rd;
                    end
                    else
                    begin
                        used_head_next = next_rd;
                    end
                    prev_we    = next_rd != NIL_LINK;
                    prev_waddr = next_rd[IDX_W-1:0];
                    prev_wdata = prev_rd;
                    use_we     = 1'b1;
                end
            end
            ST_DEL2:
            begin
                next_we    = 1'b1;
                next_wdata = free_head_reg;
                prev_we    = 1'b1;
            end
            ST_DEL3:
            begin
                prev_we        = free_head_reg != NIL_LINK;
                prev_waddr     = free_head_reg[IDX_W-1:0];
                prev_wdata     = LINK_W'(slot_reg);
                free_head_next = LINK_W'(slot_reg);
                count_next     = count_reg - CNT_W'(1);
                ok_next        = 1'b1;
            end
            ST_FIND:
            begin
                rd_addr = next_rd[IDX_W-1:0];
                if (key_match)
                begin
                    ok_next     = 1'b1;
                    result_next = slot_reg;
                end
                else
                begin
                    slot_next = next_rd[IDX_W-1:0];
                end
            end
            ST_DONE:
            begin
                out_valid_next      = 1'b1;
                out_ok_next         = ok_reg;
                out_slot_next       = result_ext[SLOT_W-1:0];
                out_count_next      = count_ext[COUNT_W-1:0];
                out_head_valid_next = used_head_reg != NIL_LINK;
                out_head_next       = (used_head_reg != NIL_LINK) ? head_ext[SLOT_W-1:0] : '0;
            end
            default:
            begin
                rd_addr = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            free_head_reg <= '0;
            used_head_reg <= NIL_LINK;
            count_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg            <= key_next;
        aux_reg            <= aux_next;
        ok_reg             <= ok_next;
        result_reg         <= result_next;
        out_ok_reg         <= out_ok_next;
        out_slot_reg       <= out_slot_next;
        out_count_reg      <= out_count_next;
        out_head_reg       <= out_head_next;
        out_head_valid_reg <= out_head_valid_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.head_slot   = out_head_reg;
    assign rsp.head_valid  = out_head_valid_reg;

endmodule

>>> src/plnt_ram.sv
`timescale 1ns / 1ps

module plnt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> test/plnt_table_checker.sv
`timescale 1ns / 1ps

module plnt_table_checker #(
    parameter int unsigned POOL_ENTRIES = 32,
    parameter int unsigned NAME_BYTES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    plnt_req_if         req,
    plnt_rsp_if         rsp,
    output int unsigned fail_count,
    output int unsigned due_count
);

    import plnt_pkg::*;

    localparam logic [5:0] NIL = 6'(POOL_ENTRIES);

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  head;
        logic               head_v;
    } table_result_t;

    logic [KEY_W-1:0] names  [POOL_ENTRIES];
    logic [5:0]       nxt    [POOL_ENTRIES];
    logic [5:0]       prv    [POOL_ENTRIES];
    logic             in_use [POOL_ENTRIES];
    logic [5:0]       free_hd;
    logic [5:0]       used_hd;
    logic [COUNT_W-1:0] used_cnt;

    table_result_t results_due[$];
    table_result_t want;
    table_result_t got;

    function automatic logic [KEY_W-1:0] name_of(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        logic             stop;
        k    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= NAME_BYTES || raw[8*i +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                k[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return k;
    endfunction

    task automatic clear_table();
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            names[i]  = '0;
            nxt[i]    = 6'(i + 1);
            prv[i]    = (i == 0) ? NIL : 6'(i - 1);
            in_use[i] = 1'b0;
        end
        free_hd  = 6'd0;
        used_hd  = NIL;
        used_cnt = '0;
    endtask

    function automatic table_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                    input logic [KEY_W-1:0] raw,
                                                    input logic [SLOT_W-1:0] handle,
                                                    input logic hv);
        table_result_t    r;
        logic [KEY_W-1:0] key;
        logic [5:0]       s;
        logic [5:0]       p;
        logic [5:0]       n;
        logic [5:0]       w;
        logic             found;
        int               steps;
        r     = '0;
        key   = name_of(raw);
        found = 1'b0;
        case (kind)
            REQ_ADD:
            begin
                if (free_hd != NIL)
                begin
                    s = free_hd;
                    n = nxt[s];
                    nxt[s] = used_hd;
                    prv[s] = NIL;
                    if (used_hd != NIL)
                    begin
                        prv[used_hd] = s;
                    end
                    used_hd = s;
                    free_hd = n;
                    if (n != NIL)
                    begin
                        prv[n] = NIL;
                    end
                    names[s]  = key;
                    in_use[s] = 1'b1;
                    used_cnt  = used_cnt + 1'b1;
                    r.ok   = 1'b1;
                    r.slot = s[SLOT_W-1:0];
                end
            end
            REQ_DELETE:
            begin
                if (!hv)
                begin
                    r.ok = 1'b1;
                end
                else if (in_use[handle])
                begin
                    s = 6'(handle);
                    p = prv[s];
                    n = nxt[s];
                    if (p != NIL)
                    begin
                        nxt[p] = n;
                    end
                    else
                    begin
                        used_hd = n;
                    end
                    if (n != NIL)
                    begin
                        prv[n] = p;
                    end
                    prv[s] = NIL;
                    nxt[s] = free_hd;
                    if (free_hd != NIL)
                    begin
                        prv[free_hd] = s;
                    end
                    free_hd   = s;
                    names[s]  = '0;
                    in_use[s] = 1'b0;
                    used_cnt  = used_cnt - 1'b1;
                    r.ok = 1'b1;
                end
            end
            REQ_FIND:
            begin
                w = used_hd;
                for (steps = 0; steps < POOL_ENTRIES && w != NIL && !found; steps++)
                begin
                    if (names[w] == key)
                    begin
                        found  = 1'b1;
                        r.ok   = 1'b1;
                        r.slot = w[SLOT_W-1:0];
                    end
                    else
                    begin
                        w = nxt[w];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count  = used_cnt;
        r.head_v = (used_hd != NIL);
        r.head   = (used_hd != NIL) ? used_hd[SLOT_W-1:0] : '0;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        due_count  = 0;
        clear_table();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            results_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.ok     = rsp.ok;
                got.slot   = rsp.result_slot;
                got.count  = rsp.entry_count;
                got.head   = rsp.head_slot;
                got.head_v = rsp.head_valid;
                if (results_due.size() == 0)
                begin
                    $display("%0t: result beat with none outstanding: ok=%b slot=%0d count=%0d head=%0d hv=%b",
                             $time, got.ok, got.slot, got.count, got.head, got.head_v);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected ok=%b slot=%0d count=%0d head=%0d hv=%b, actual ok=%b slot=%0d count=%0d head=%0d hv=%b",
                                 $time, want.ok, want.slot, want.count, want.head, want.head_v,
                                 got.ok, got.slot, got.count, got.head, got.head_v);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                results_due.push_back(apply_request(req.req_type, req.name_key,
                                                    req.slot_handle, req.handle_valid));
            end
            due_count <= results_due.size();
        end
    end

    final
    begin
    end

endmodule

>>> test/tb_pooled_list_name_table_core.sv
`timescale 1ns / 1ps

module tb_pooled_list_name_table_core;

    import plnt_pkg::*;

    localparam int unsigned POOL_ENTRIES = 32;
    localparam int unsigned NAME_BYTES   = 8;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          BANK_SIZE    = 12;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    plnt_req_if req_ch();
    plnt_rsp_if rsp_ch();

    int unsigned fail_count;
    int unsigned due_count;

    int hold_requests = 0;
    int holds_served  = 0;
    int burst_left    = 0;
    int items_sent    = 0;

    logic [KEY_W-1:0] bank_name [BANK_SIZE];
    int               bank_len  [BANK_SIZE];

    pooled_list_name_table_core #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .NAME_BYTES   (NAME_BYTES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    plnt_table_checker #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .NAME_BYTES   (NAME_BYTES)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    always #5 clk = ~clk;

    function automatic logic [KEY_W-1:0] pick_name();
        logic [KEY_W-1:0] k;
        int               r;
        int               i;
        int               n;
        r = $urandom_range(0, 99);
        i = $urandom_range(0, BANK_SIZE - 1);
        k = '0;
        if (r < 50)
        begin
            k = bank_name[i];
        end
        else if (r < 70)
        begin
            // same name, junk after the terminating zero
            k = bank_name[i];
            for (int b = bank_len[i] + 1; b < 8; b++)
            begin
                k[8*b +: 8] = 8'($urandom_range(0, 255));
            end
        end
        else if (r < 90)
        begin
            k = {$urandom, $urandom};
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (int b = 0; b < n; b++)
            begin
                k[8*b +: 8] = 8'($urandom_range(1, 255));
            end
        end
        return k;
    endfunction

    task automatic offer_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                                 input logic [SLOT_W-1:0] handle, input logic hv);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.name_key     <= key;
        req_ch.slot_handle  <= handle;
        req_ch.handle_valid <= hv;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (due_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    // receiver
    initial
    begin
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ((tick % 5) < 3);
            endcase
        end
    end

    // watchdog
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        phase_kind_t      ph;
        int               phase_no;
        int               phase_len;
        int               r;
        int               stop_at;
        logic [REQ_W-1:0] kind;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] handle;
        logic             hv;

        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ADD;
        req_ch.name_key     = '0;
        req_ch.slot_handle  = '0;
        req_ch.handle_valid = 1'b0;

        for (int i = 0; i < BANK_SIZE; i++)
        begin
            bank_len[i]  = $urandom_range(0, 8);
            bank_name[i] = '0;
            for (int b = 0; b < bank_len[i]; b++)
            begin
                bank_name[i][8*b +: 8] = 8'($urandom_range(1, 255));
            end
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer_request(REQ_FIND,    64'h0, 5'd0, 1'b0);
        offer_request(REQ_DELETE,  64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b0);
        offer_request(REQ_DELETE,  64'h0, 5'd0, 1'b1);
        offer_request(REQ_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1);
        offer_request(REQ_ADD,     64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0);
        offer_request(REQ_ADD,     64'h0, 5'd31, 1'b1);
        offer_request(REQ_ADD,     64'h1122_3300_4455_6677, 5'd0, 1'b0);
        offer_request(REQ_ADD,     64'h0102_0304_0506_0708, 5'd0, 1'b0);
        offer_request(REQ_FIND,    64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0);
        offer_request(REQ_FIND,    64'hAAAA_AA00_4455_6677, 5'd0, 1'b0);
        offer_request(REQ_FIND,    64'h0000_0000_4455_6677, 5'd0, 1'b0);
        offer_request(REQ_FIND,    64'h0, 5'd0, 1'b0);
        offer_request(REQ_FIND,    64'h0000_0000_0000_FF00, 5'd0, 1'b0);
        offer_request(REQ_DELETE,  64'h0, 5'd31, 1'b1);
        offer_request(REQ_DELETE,  64'h0, 5'd2, 1'b1);
        offer_request(REQ_FIND,    64'h0000_0000_4455_6677, 5'd0, 1'b0);
        offer_request(REQ_DELETE,  64'h0, 5'd3, 1'b1);
        offer_request(REQ_DELETE,  64'h0, 5'd0, 1'b1);
        offer_request(REQ_ADD,     64'h8000_0000_0000_0001, 5'd0, 1'b0);
        offer_request(REQ_FIND,    64'h0102_0304_0506_0708, 5'd0, 1'b0);
        wait_for_drain();

        stop_at  = items_sent + RANDOM_ITEMS;
        phase_no = 0;
        while (items_sent < stop_at)
        begin
            case (phase_no)
                0:       ph = PH_FILL;
                1:       ph = PH_MIXED;
                2:       ph = PH_DRAIN;
                default: ph = phase_kind_t'($urandom_range(0, 2));
            endcase
            phase_len = $urandom_range(30, 60);
            if (phase_no == 2 || $urandom_range(0, 2) == 0)
            begin
                wait_for_drain();
            end
            if (phase_no == 1 || $urandom_range(0, 4) == 0)
            begin
                hold_requests++;
            end
            repeat (phase_len)
            begin
                r      = $urandom_range(0, 99);
                key    = pick_name();
                handle = 5'($urandom_range(0, 31));
                hv     = 1'b1;
                kind   = REQ_FIND;
                if ($urandom_range(0, 99) < 3)
                begin
                    kind = 2'($urandom_range(0, 3));
                    key  = {$urandom, $urandom};
                    hv   = 1'($urandom_range(0, 1));
                end
                else
                begin
                    case (ph)
                        PH_FILL:
                        begin
                            kind = (r < 85) ? REQ_ADD : REQ_FIND;
                        end
                        PH_DRAIN:
                        begin
                            if (r < 65)
                            begin
                                kind = REQ_DELETE;
                            end
                            else if (r < 75)
                            begin
                                kind = REQ_DELETE;
                                hv   = ($urandom_range(0, 3) == 0);
                            end
                            else if (r < 90)
                            begin
                                kind = REQ_FIND;
                            end
                            else
                            begin
                                kind = REQ_ADD;
                            end
                        end
                        default:
                        begin
                            if (r < 35)
                            begin
                                kind = REQ_ADD;
                            end
                            else if (r < 65)
                            begin
                                kind = REQ_DELETE;
                                hv   = ($urandom_range(0, 9) != 0);
                            end
                            else if (r < 95)
                            begin
                                kind = REQ_FIND;
                            end
                            else
                            begin
                                kind = REQ_UNKNOWN;
                            end
                        end
                    endcase
                end
                offer_request(kind, key, handle, hv);
            end
            phase_no++;
        end

        wait_for_drain();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
src/plnt_pkg.sv
src/plnt_if.sv
src/plnt_ram.sv
src/pooled_list_name_table_core.sv
test/plnt_table_checker.sv
test/tb_pooled_list_name_table_core.sv
